// ===== rtl/core/rav_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rav_pkg: shared definitions for the running average filter
// Widths, reset values, sequencer states and window clamping.
// ----------------------------------------------------------------------------
package rav_pkg;

    localparam int CFG_W           = 6;
    localparam int WINDOW_MAX_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int WINDOW_RESET    = 20;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_START,
        ST_DIVIDE,
        ST_DONE
    } rav_state_t;

    // zero acts as one, values above the cap saturate
    function automatic logic [CFG_W-1:0] eff_window(
        input logic [CFG_W-1:0] ws,
        input logic [CFG_W-1:0] cap
    );
        logic [CFG_W-1:0] w;
        w = ws;
        if (w == '0)
        begin
            w = CFG_W'(1);
        end
        if (w > cap)
        begin
            w = cap;
        end
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rav_ring.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rav_ring: sample ring store
// One write and one registered read per cycle; valid bits make unwritten
// entries read as zero and are cleared at once.
// ----------------------------------------------------------------------------
module rav_ring #(
    parameter int WINDOW_MAX  = 32,
    parameter int SAMPLE_BITS = 16,
    parameter int PTR_W       = $clog2(WINDOW_MAX)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          clear,
    input  wire logic                          rd_en,
    input  wire logic [PTR_W-1:0]              rd_addr,
    input  wire logic                          wr_en,
    input  wire logic [PTR_W-1:0]              wr_addr,
    input  wire logic signed [SAMPLE_BITS-1:0] wr_data,
    output logic signed [SAMPLE_BITS-1:0]      rd_data
);

    logic signed [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]         vld_reg;
    logic [WINDOW_MAX-1:0]         vld_next;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic                          rd_vld_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (clear)
        begin
            vld_next = '0;
        end
        else if (wr_en)
        begin
            vld_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule
`default_nettype wire

// ===== rtl/core/rav_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rav_divider: serial restoring divider
// Unsigned divide, one quotient bit per cycle, done pulses after the last.
// ----------------------------------------------------------------------------
module rav_divider #(
    parameter int DIVIDEND_W = 22,
    parameter int DIVISOR_W  = 6
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] dvd_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  qbit;
    logic [DIVISOR_W-1:0]  rem_next;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DIVIDEND_W-1]};
        diff     = trial - {1'b0, div_reg};
        qbit     = (trial >= {1'b0, div_reg});
        rem_next = qbit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIVIDEND_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule
`default_nettype wire

// ===== rtl/core/running_average_filter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// running_average_filter_core: moving average over a ring of recent samples
// Keeps a running sum over the last window_size samples and divides it by
// the number of samples held, quotient truncated toward zero.
// ----------------------------------------------------------------------------
//   channel   handshake             payload
//   input     in_valid / in_stall   sample
//   output    out_valid / out_stall average, samples_held
//   config    cfg_valid / cfg_ready window_size
//
// An item passes through ST_UPDATE, ST_START, ST_DIVIDE and ST_DONE; the serial
// divider produces one quotient bit per cycle in ST_DIVIDE.
// Reset and any window_size write clear the ring at once through valid bits.
// The result waits in an output register; a new item is accepted meanwhile.
// cfg_ready is high only while no item is in progress; a waiting write
// holds off the input.
// ----------------------------------------------------------------------------
module running_average_filter_core #(
    parameter int WINDOW_MAX  = rav_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = rav_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0]      average,
    output logic [rav_pkg::CFG_W-1:0]          samples_held,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rav_pkg::CFG_W-1:0]     window_size
);

    import rav_pkg::*;

    localparam int PTR_W   = $clog2(WINDOW_MAX);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_MAX) + 1;
    localparam int CAP_INT = (WINDOW_MAX > (2 ** CFG_W) - 1) ? (2 ** CFG_W) - 1 : WINDOW_MAX;
    localparam logic [CFG_W-1:0] WIN_CAP = CFG_W'(CAP_INT);

    rav_state_t state_reg;
    rav_state_t state_next;

    logic [CFG_W-1:0]              win_reg;
    logic [CFG_W-1:0]              pos_reg;
    logic [CFG_W-1:0]              held_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          neg_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] average_reg;
    logic [CFG_W-1:0]              held_out_reg;

    logic                          in_accept;
    logic                          cfg_write;
    logic                          out_free;
    logic [PTR_W-1:0]              ring_addr;
    logic signed [SAMPLE_BITS-1:0] old_sample;
    logic                          ring_wr;
    logic                          div_start;
    logic                          div_done;
    logic [SUM_W-1:0]              div_quo;
    logic [SUM_W-1:0]              sum_mag;
    logic [SAMPLE_BITS-1:0]        quo_trunc;
    logic [CFG_W-1:0]              pos_inc;

    assign in_accept = in_valid && !in_stall;
    assign cfg_write = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || !out_stall;
    assign ring_addr = PTR_W'(pos_reg);
    assign sum_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign quo_trunc = div_quo[SAMPLE_BITS-1:0];
    assign pos_inc   = pos_reg + CFG_W'(1);

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        cfg_ready  = 1'b0;
        ring_wr    = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall  = cfg_valid;
                cfg_ready = 1'b1;
                if (in_valid && !cfg_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                ring_wr    = 1'b1;
                state_next = ST_START;
            end
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_reg       <= eff_window(CFG_W'(WINDOW_RESET), WIN_CAP);
            pos_reg       <= '0;
            held_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                win_reg  <= eff_window(window_size, WIN_CAP);
                pos_reg  <= '0;
                held_reg <= '0;
                sum_reg  <= '0;
            end
            else if (ring_wr)
            begin
                sum_reg  <= sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
                pos_reg  <= (pos_inc >= win_reg) ? '0 : pos_inc;
                if (held_reg < win_reg)
                begin
                    held_reg <= held_reg + CFG_W'(1);
                end
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= sample;
        end
        if (div_start)
        begin
            neg_reg <= sum_reg[SUM_W-1];
        end
        if (state_reg == ST_DONE && out_free)
        begin
            average_reg  <= neg_reg ? -quo_trunc : quo_trunc;
            held_out_reg <= held_reg;
        end
    end

    rav_ring #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .PTR_W       (PTR_W)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (cfg_write),
        .rd_en   (in_accept),
        .rd_addr (ring_addr),
        .wr_en   (ring_wr),
        .wr_addr (ring_addr),
        .wr_data (sample_reg),
        .rd_data (old_sample)
    );

    rav_divider #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CFG_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (held_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_valid    = out_valid_reg;
    assign average      = average_reg;
    assign samples_held = held_out_reg;

endmodule
`default_nettype wire

// ===== tb/running_average_filter_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_average_filter_core_tb: self-checking bench for the moving average
// Drives signed samples through the valid/stall input, rewrites window_size
// between phases while the filter is empty, and compares every average and
// held count against a ring-store predictor kept inside the bench. Idling on
// both channels and a long output hold exercise the handshakes.
// ----------------------------------------------------------------------------
module running_average_filter_core_tb;

    import rav_pkg::*;

    localparam int SW          = SAMPLE_BITS_DEF;
    localparam int WMAX        = WINDOW_MAX_DEF;
    localparam int DRAIN_WAIT  = 30;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef enum int {
        RUN_RANDOM,
        RUN_MAX,
        RUN_MIN,
        RUN_NEAR_ZERO,
        RUN_ALTERNATE
    } run_kind_t;

    typedef struct packed {
        logic signed [SW-1:0] average;
        logic [CFG_W-1:0]     held;
    } avg_result_t;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic signed [SW-1:0]  sample       = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic signed [SW-1:0]  average;
    logic [CFG_W-1:0]      samples_held;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      window_size  = CFG_W'(WINDOW_RESET);

    // predictor state
    logic signed [SW-1:0]  ring [WMAX];
    longint                ring_sum;
    int                    ring_pos;
    int                    ring_count;
    logic [CFG_W-1:0]      window_reg;

    avg_result_t           pending_averages[$];
    int                    mismatches   = 0;

    int                    gap_pct      = 0;
    int                    stall_pct    = 0;
    logic                  hold_trigger = 1'b0;
    logic                  hold_seen    = 1'b0;
    int                    hold_left    = 0;

    run_kind_t             run_kind     = RUN_RANDOM;
    int                    run_left     = 0;
    logic                  alt_phase    = 1'b0;

    running_average_filter_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .average      (average),
        .samples_held (samples_held),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .window_size  (window_size)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int clamp_window(input logic [CFG_W-1:0] w);
        int n;
        n = int'(w);
        if (n < 1)
        begin
            n = 1;
        end
        if (n > WMAX)
        begin
            n = WMAX;
        end
        return n;
    endfunction

    task automatic clear_ring();
        for (int i = 0; i < WMAX; i++)
        begin
            ring[i] = '0;
        end
        ring_sum   = 0;
        ring_pos   = 0;
        ring_count = 0;
    endtask

    function automatic avg_result_t predict_average(input logic signed [SW-1:0] s);
        avg_result_t r;
        int          win;
        longint      quotient;
        win = clamp_window(window_reg);
        if (ring_pos >= win)
        begin
            ring_pos = 0;
        end
        ring_sum       = ring_sum - longint'(ring[ring_pos]) + longint'(s);
        ring[ring_pos] = s;
        ring_pos       = ring_pos + 1;
        if (ring_pos >= win)
        begin
            ring_pos = 0;
        end
        if (ring_count < win)
        begin
            ring_count = ring_count + 1;
        end
        quotient  = ring_sum / longint'(ring_count);
        r.average = SW'(quotient);
        r.held    = CFG_W'(ring_count);
        return r;
    endfunction

    // receiver: random stalls plus an occasional long hold
    always @(posedge clk)
    begin
        if (hold_trigger != hold_seen)
        begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic note_mismatch(input string what, input int exp_v, input int act_v);
        if (mismatches < MAX_REPORTS)
        begin
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_v,
                     act_v);
        end
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        avg_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_averages.size() == 0)
            begin
                note_mismatch("unexpected result, average", 0, int'(average));
            end
            else
            begin
                want = pending_averages.pop_front();
                if (average !== want.average)
                begin
                    note_mismatch("average", int'(want.average), int'(average));
                end
                if (samples_held !== want.held)
                begin
                    note_mismatch("samples_held", int'(want.held), int'(samples_held));
                end
            end
        end
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                gap_pct   = 0;
                stall_pct <= 0;
            end
            IDLE_SENDER:
            begin
                gap_pct   = 55;
                stall_pct <= 0;
            end
            IDLE_RECEIVER:
            begin
                gap_pct   = 0;
                stall_pct <= 55;
            end
            default:
            begin
                gap_pct   = 21;
                stall_pct <= 21;
            end
        endcase
    endtask

    task automatic send_sample(input logic signed [SW-1:0] v);
        int gap;
        gap = 0;
        if (gap_pct != 0)
        begin
            while ($urandom_range(99) < gap_pct)
            begin
                gap++;
            end
            if ($urandom_range(9) == 0)
            begin
                gap += $urandom_range(40);
            end
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= v;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        pending_averages.push_back(predict_average(v));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_averages.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] w);
        wait_for_results();
        cfg_valid   <= 1'b1;
        window_size <= w;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        window_reg = w;
        clear_ring();
    endtask

    task automatic next_sample(output logic signed [SW-1:0] v);
        if (run_left == 0)
        begin
            run_kind = run_kind_t'($urandom_range(4));
            run_left = $urandom_range(1, 40);
        end
        run_left--;
        case (run_kind)
            RUN_MAX:       v = {1'b0, {(SW-1){1'b1}}};
            RUN_MIN:       v = {1'b1, {(SW-1){1'b0}}};
            RUN_NEAR_ZERO: v = SW'($urandom_range(200)) - SW'(100);
            RUN_ALTERNATE:
            begin
                alt_phase = ~alt_phase;
                v = alt_phase ? {1'b0, {(SW-1){1'b1}}} : {1'b1, {(SW-1){1'b0}}};
            end
            default:       v = SW'($urandom);
        endcase
    endtask

    task automatic test_reset_window();
        set_idling(IDLE_NONE);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'shffff);
        send_sample(16'sh0001);
        send_sample(16'shfffd);
        for (int i = 0; i < 16; i++)
        begin
            send_sample(16'sh7fff);
        end
    endtask

    task automatic test_window_zero();
        write_window(CFG_W'(0));
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(-16'sd7);
    endtask

    task automatic test_input_backpressure();
        set_idling(IDLE_NONE);
        write_window(CFG_W'(WMAX));
        hold_trigger <= ~hold_trigger;
        for (int i = 0; i < 40; i++)
        begin
            send_sample(16'sh8000);
        end
    endtask

    task automatic test_random_windows();
        logic [CFG_W-1:0]     edges [10];
        logic [CFG_W-1:0]     w;
        logic signed [SW-1:0] v;
        edges = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd32, 6'd33, 6'd63, 6'd20, 6'd31, 6'd5};
        for (int ph = 0; ph < 15; ph++)
        begin
            w = (ph < 10) ? edges[ph] : CFG_W'($urandom_range(63));
            write_window(w);
            set_idling(idle_mode_t'(ph % 4));
            for (int i = 0; i < 80; i++)
            begin
                next_sample(v);
                send_sample(v);
            end
        end
    endtask

    initial
    begin
        window_reg = CFG_W'(WINDOW_RESET);
        clear_ring();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_window();
        test_window_zero();
        test_input_backpressure();
        test_random_windows();

        wait_for_results();
        if (mismatches == 0 && pending_averages.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rav_pkg.sv
rtl/core/rav_ring.sv
rtl/core/rav_divider.sv
rtl/core/running_average_filter_core.sv
tb/running_average_filter_core_tb.sv
